[rtl/multi_queue_manager_defines.svh]
// Assertion macros shared by the RTL that checks itself.
`ifndef MULTI_QUEUE_MANAGER_DEFINES_SVH
`define MULTI_QUEUE_MANAGER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define MQM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define MQM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mqm_pkg.sv]
`default_nettype none

package mqm_pkg;

    localparam int QID_W    = 4;
    localparam int QID_SPAN = 16;
    localparam int TAG_W    = 8;
    localparam int SER_W    = 16;
    localparam int ST_W     = 2;
    localparam int AQ_W     = 5;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_SEL_BIT = 2;

    localparam logic [SER_W-1:0] SERIAL_FIRST = 16'd1;
    localparam logic [SER_W-1:0] SERIAL_LAST  = 16'hFFFF;

    typedef enum logic [0:0] {
        REG_ACTIVE_QUEUES = 1'b0,
        REG_NONE          = 1'b1
    } reg_sel_t;

    typedef enum logic [0:0] {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_BADQ  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic take;
        logic put;
    } pool_op_t;

    typedef struct packed {
        logic data_we;
        logic link_we;
        logic rd_en;
    } store_op_t;

endpackage

`default_nettype wire

[rtl/mqm_if.sv]
`default_nettype none

interface mqm_req_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [mqm_pkg::QID_W-1:0]   queue_id;
    logic [mqm_pkg::TAG_W-1:0]   dest_tag;

    modport source (output valid, cmd, queue_id, dest_tag, input ready);
    modport sink   (input valid, cmd, queue_id, dest_tag, output ready);
endinterface

interface mqm_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [mqm_pkg::ST_W-1:0]    status;
    logic [mqm_pkg::SER_W-1:0]   serial;
    logic [mqm_pkg::TAG_W-1:0]   tag_out;

    modport source (output valid, status, serial, tag_out, input ready);
    modport sink   (input valid, status, serial, tag_out, output ready);
endinterface

`default_nettype wire

[rtl/multi_queue_manager.sv]
// multi_queue_manager: up to sixteen FIFOs sharing one entry pool.
// req channel (valid/ready): one beat is one command, cmd 0 enqueues dest_tag
//   on queue queue_id, cmd 1 dequeues the head of queue queue_id.
// rsp channel (valid/ready): exactly one beat per command, in command order,
//   carrying status (ok, bad queue, queue empty, pool full), serial and tag.
// APB port: register 0 (byte address 0) is active_queues; queue numbers at
//   or above it, or at or above NUM_QUEUES, are rejected. Write it only when idle.
// Throughput: one command per cycle while the result register is not stalled.
//   The pointer table is updated in the accept cycle; the pool memories are read
//   at accept and their registered data is consumed when the middle stage
//   advances, with a forward of the new head.
// Reset: all queues empty, every pool entry free, serial counter at 1,
//   active_queues at 0. No memory sweep is run; the block is ready at once.
// Stall: the result register holds while rsp.ready is low; one more command
//   is accepted into the middle stage, after which req.ready drops until
//   the result is taken.
`default_nettype none
`include "multi_queue_manager_defines.svh"

module multi_queue_manager #(
    parameter int NUM_QUEUES   = 16,
    parameter int POOL_ENTRIES = 256
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [mqm_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire [mqm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mqm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    mqm_req_if.sink                            req,
    mqm_rsp_if.source                          rsp
);

    // Queues beyond what queue_id can name are never reachable.
    localparam int NQ = (NUM_QUEUES < mqm_pkg::QID_SPAN) ? NUM_QUEUES : mqm_pkg::QID_SPAN;
    localparam int QW = (NQ > 1) ? $clog2(NQ) : 1;
    localparam int PW = $clog2(POOL_ENTRIES);

    // ---------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------
    logic [mqm_pkg::AQ_W-1:0] active_reg, active_next;
    logic                     reg_hit;

    always_comb
    begin
        reg_hit     = (mqm_pkg::reg_sel_t'(paddr[mqm_pkg::REG_SEL_BIT])
                       == mqm_pkg::REG_ACTIVE_QUEUES);
        active_next = active_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            active_next = pwdata[mqm_pkg::AQ_W-1:0];
        end
        prdata = reg_hit ? mqm_pkg::APB_DATA_W'(active_reg) : '0;
    end

    assign pready = 1'b1;

    // ---------------------------------------------------------------
    // Queue table: head, tail, occupancy per queue
    // ---------------------------------------------------------------
    logic [PW-1:0] head_reg [NQ];
    logic [PW-1:0] tail_reg [NQ];
    logic [NQ-1:0] nonempty_reg, nonempty_next;

    // A dequeue that leaves its queue non-empty learns the new head from
    // the link memory's read register; hold which queue is waiting for it.
    logic          upd_valid_reg, upd_valid_next;
    logic [QW-1:0] upd_q_reg;

    logic [mqm_pkg::SER_W-1:0] next_serial_reg, next_serial_next;

    // ---------------------------------------------------------------
    // Pool interfaces
    // ---------------------------------------------------------------
    mqm_pkg::pool_op_t  pool_op;
    mqm_pkg::store_op_t store_op;
    logic               pool_avail;
    logic [PW-1:0]      alloc_idx;
    logic [mqm_pkg::SER_W-1:0] rd_serial;
    logic [mqm_pkg::TAG_W-1:0] rd_tag;
    logic [PW-1:0]      link_rd;

    // ---------------------------------------------------------------
    // Accept stage: decode, check, decide
    // ---------------------------------------------------------------
    logic            accept;
    logic [QW-1:0]   qidx;
    logic            is_deq;
    logic            bad_q;
    logic            q_busy;
    logic [PW-1:0]   head_q;
    logic [PW-1:0]   tail_q;
    logic            enq_ok;
    logic            deq_ok;
    logic            last_q;
    mqm_pkg::status_t st;

    always_comb
    begin
        qidx   = QW'(req.queue_id);
        is_deq = (mqm_pkg::cmd_t'(req.cmd) == mqm_pkg::CMD_DEQ);
        bad_q  = ({1'b0, req.queue_id} >= active_reg)
                 || (32'(req.queue_id) >= NUM_QUEUES);
        q_busy = nonempty_reg[qidx];
        // Forward the head still in flight from the previous dequeue.
        head_q = (upd_valid_reg && (upd_q_reg == qidx)) ? link_rd : head_reg[qidx];
        tail_q = tail_reg[qidx];
        enq_ok = !bad_q && !is_deq && pool_avail;
        deq_ok = !bad_q && is_deq && q_busy;
        last_q = (head_q == tail_q);
        if (bad_q)
        begin
            st = mqm_pkg::ST_BADQ;
        end
        else if (is_deq)
        begin
            st = q_busy ? mqm_pkg::ST_OK : mqm_pkg::ST_EMPTY;
        end
        else
        begin
            st = pool_avail ? mqm_pkg::ST_OK : mqm_pkg::ST_FULL;
        end
    end

    // Middle stage and result register handshake.
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;
    logic s2_adv;

    assign s2_adv    = !out_valid_reg || rsp.ready;
    assign req.ready = !s2_valid_reg || s2_adv;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        pool_op.take     = accept && enq_ok;
        pool_op.put      = accept && deq_ok;
        store_op.data_we = accept && enq_ok;
        store_op.link_we = accept && enq_ok && q_busy;
        store_op.rd_en   = accept && deq_ok;
    end

    // Serial counter skips zero on wrap; a rejected enqueue leaves it alone.
    always_comb
    begin
        next_serial_next = next_serial_reg;
        if (accept && enq_ok)
        begin
            next_serial_next = (next_serial_reg == mqm_pkg::SERIAL_LAST)
                               ? mqm_pkg::SERIAL_FIRST
                               : next_serial_reg + 1'b1;
        end
    end

    always_comb
    begin
        nonempty_next = nonempty_reg;
        if (accept && enq_ok)
        begin
            nonempty_next[qidx] = 1'b1;
        end
        if (accept && deq_ok && last_q)
        begin
            nonempty_next[qidx] = 1'b0;
        end
        upd_valid_next = accept && deq_ok && !last_q;
    end

    always_ff @(posedge clk)
    begin
        // Land the deferred head first; a new write from this beat wins.
        if (upd_valid_reg)
        begin
            head_reg[upd_q_reg] <= link_rd;
        end
        if (accept && enq_ok)
        begin
            tail_reg[qidx] <= alloc_idx;
            if (!q_busy)
            begin
                head_reg[qidx] <= alloc_idx;
            end
        end
        upd_q_reg <= qidx;
    end

    mqm_free_pool #(
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_pool (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (pool_op),
        .put_idx  (head_q),
        .avail    (pool_avail),
        .take_idx (alloc_idx)
    );

    mqm_entry_store #(
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_store (
        .clk       (clk),
        .op        (store_op),
        .wr_idx    (alloc_idx),
        .wr_serial (next_serial_reg),
        .wr_tag    (req.dest_tag),
        .link_idx  (tail_q),
        .link_val  (alloc_idx),
        .rd_idx    (head_q),
        .rd_serial (rd_serial),
        .rd_tag    (rd_tag),
        .rd_link   (link_rd)
    );

    // ---------------------------------------------------------------
    // Middle stage: hold the decided result; dequeues take the popped
    // serial and tag from the store's read register.
    // ---------------------------------------------------------------
    mqm_pkg::status_t          s2_status_reg;
    logic [mqm_pkg::SER_W-1:0] s2_serial_reg;
    logic [mqm_pkg::TAG_W-1:0] s2_tag_reg;
    logic                      s2_from_mem_reg;

    mqm_pkg::status_t          out_status_reg;
    logic [mqm_pkg::SER_W-1:0] out_serial_reg;
    logic [mqm_pkg::TAG_W-1:0] out_tag_reg;

    always_comb
    begin
        if (accept)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_next = 1'b0;
        end
        else
        begin
            s2_valid_next = s2_valid_reg;
        end
        out_valid_next = s2_adv ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_status_reg   <= st;
            s2_serial_reg   <= enq_ok ? next_serial_reg : '0;
            s2_tag_reg      <= enq_ok ? req.dest_tag : '0;
            s2_from_mem_reg <= deq_ok;
        end
        if (s2_adv && s2_valid_reg)
        begin
            out_status_reg <= s2_status_reg;
            out_serial_reg <= s2_from_mem_reg ? rd_serial : s2_serial_reg;
            out_tag_reg    <= s2_from_mem_reg ? rd_tag : s2_tag_reg;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.serial  = out_serial_reg;
    assign rsp.tag_out = out_tag_reg;

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= '0;
            nonempty_reg    <= '0;
            upd_valid_reg   <= 1'b0;
            next_serial_reg <= mqm_pkg::SERIAL_FIRST;
            s2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            active_reg      <= active_next;
            nonempty_reg    <= nonempty_next;
            upd_valid_reg   <= upd_valid_next;
            next_serial_reg <= next_serial_next;
            s2_valid_reg    <= s2_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    logic pop_held;
    logic ok_beat;

    // A popped entry waiting in the middle stage behind a stalled result.
    assign pop_held = s2_valid_reg && s2_from_mem_reg && !s2_adv;
    assign ok_beat  = rsp.valid && (rsp.status == mqm_pkg::ST_OK);

    `MQM_ASSERT_IMPL(a_pending_head_live, upd_valid_reg, nonempty_reg[upd_q_reg], "stale head update")
    `MQM_ASSERT_IMPL(a_stall_blocks_accept, s2_valid_reg && !s2_adv, !req.ready, "accept in stall")
    `MQM_ASSERT_NEXT(a_pop_data_held, pop_held, $stable(rd_serial) && $stable(rd_tag), "pop data lost")
    `MQM_ASSERT_IMPL(a_ok_has_serial, ok_beat, rsp.serial != '0, "ok beat with serial zero")

endmodule

`default_nettype wire

[rtl/mqm_entry_store.sv]
`default_nettype none

module mqm_entry_store #(
    parameter int POOL_ENTRIES = 256
) (
    input  wire                              clk,
    input  wire mqm_pkg::store_op_t          op,
    input  wire [$clog2(POOL_ENTRIES)-1:0]   wr_idx,
    input  wire [mqm_pkg::SER_W-1:0]         wr_serial,
    input  wire [mqm_pkg::TAG_W-1:0]         wr_tag,
    input  wire [$clog2(POOL_ENTRIES)-1:0]   link_idx,
    input  wire [$clog2(POOL_ENTRIES)-1:0]   link_val,
    input  wire [$clog2(POOL_ENTRIES)-1:0]   rd_idx,
    output logic [mqm_pkg::SER_W-1:0]        rd_serial,
    output logic [mqm_pkg::TAG_W-1:0]        rd_tag,
    output logic [$clog2(POOL_ENTRIES)-1:0]  rd_link
);

    localparam int PW = $clog2(POOL_ENTRIES);
    localparam int DW = mqm_pkg::SER_W + mqm_pkg::TAG_W;

    logic [DW-1:0] data_mem [POOL_ENTRIES];
    logic [PW-1:0] link_mem [POOL_ENTRIES];
    logic [DW-1:0] data_rd_reg;
    logic [PW-1:0] link_rd_reg;

    // Entry payload: serial and tag, written at allocation.
    always_ff @(posedge clk)
    begin
        if (op.data_we)
        begin
            data_mem[wr_idx] <= {wr_serial, wr_tag};
        end
        if (op.rd_en)
        begin
            data_rd_reg <= data_mem[rd_idx];
        end
    end

    // Successor links: written when an entry gains a follower.
    always_ff @(posedge clk)
    begin
        if (op.link_we)
        begin
            link_mem[link_idx] <= link_val;
        end
        if (op.rd_en)
        begin
            link_rd_reg <= link_mem[rd_idx];
        end
    end

    assign rd_serial = data_rd_reg[DW-1:mqm_pkg::TAG_W];
    assign rd_tag    = data_rd_reg[mqm_pkg::TAG_W-1:0];
    assign rd_link   = link_rd_reg;

endmodule

`default_nettype wire

[rtl/mqm_free_pool.sv]
`default_nettype none

module mqm_free_pool #(
    parameter int POOL_ENTRIES = 256
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire mqm_pkg::pool_op_t           op,
    input  wire [$clog2(POOL_ENTRIES)-1:0]   put_idx,
    output logic                             avail,
    output logic [$clog2(POOL_ENTRIES)-1:0]  take_idx
);

    localparam int PW = $clog2(POOL_ENTRIES);
    localparam int CW = PW + 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(POOL_ENTRIES);

    // Returned entries form a stack: top in top_reg, the one below it
    // prefetched in sec_reg, the rest in stack_mem. Indices at or above
    // fresh_reg were never handed out, so reset needs no fill sweep.
    logic [PW-1:0] stack_mem [POOL_ENTRIES];
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] fresh_reg, fresh_next;
    logic [PW-1:0] top_reg, top_next;
    logic [PW-1:0] sec_reg;
    logic [CW-1:0] spill_ptr, rd_ptr;
    logic [PW-1:0] spill_addr, rd_addr;
    logic          spill_we;
    logic          have_ret;

    always_comb
    begin
        have_ret   = (cnt_reg != '0);
        avail      = have_ret || (fresh_reg != FULL_CNT);
        take_idx   = have_ret ? top_reg : fresh_reg[PW-1:0];
        cnt_next   = cnt_reg;
        fresh_next = fresh_reg;
        top_next   = top_reg;
        spill_we   = 1'b0;
        spill_ptr  = cnt_reg - CW'(1);
        spill_addr = spill_ptr[PW-1:0];
        if (op.take)
        begin
            if (have_ret)
            begin
                top_next = sec_reg;
                cnt_next = cnt_reg - CW'(1);
            end
            else
            begin
                fresh_next = fresh_reg + CW'(1);
            end
        end
        else if (op.put)
        begin
            top_next = put_idx;
            cnt_next = cnt_reg + CW'(1);
            spill_we = have_ret;
        end
        rd_ptr  = cnt_next - CW'(2);
        rd_addr = rd_ptr[PW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            fresh_reg <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            fresh_reg <= fresh_next;
        end
    end

    // Spill the old top on a push; keep the second entry prefetched,
    // bypassing the spill when it lands where the prefetch reads.
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (spill_we)
        begin
            stack_mem[spill_addr] <= top_reg;
        end
        if (spill_we && (spill_addr == rd_addr))
        begin
            sec_reg <= top_reg;
        end
        else
        begin
            sec_reg <= stack_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
